// ----- rtl/spmc_pkg.sv -----
// Package for the superpixel mean color block: request/response structs,
// item kinds, size constants and controller states. No dependencies.
package spmc_pkg;

   localparam int MAX_LABELS_DEF      = 1024;
   localparam int MAX_PIXELS_LOG2_DEF = 20;
   localparam int LABEL_W             = 10;
   localparam int CHAN_W              = 8;
   localparam int CSR_W               = 11;

   typedef enum logic [1:0] {
      KIND_ACCUM = 2'd0,
      KIND_PAINT = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [LABEL_W-1:0] label;
      logic [CHAN_W-1:0]  in_ch0;
      logic [CHAN_W-1:0]  in_ch1;
      logic [CHAN_W-1:0]  in_ch2;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] mean_ch0;
      logic [CHAN_W-1:0] mean_ch1;
      logic [CHAN_W-1:0] mean_ch2;
      logic              empty_label;
      logic              label_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ----- rtl/spmc_div.sv -----
// Restoring divider that divides three channel sums by one shared count,
// one quotient bit per cycle. Uses spmc_pkg for channel width.
module spmc_div
   import spmc_pkg::*;
#(
   parameter int SUM_W = 28,
   parameter int CNT_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] sum0,
   input  logic [SUM_W-1:0] sum1,
   input  logic [SUM_W-1:0] sum2,
   input  logic [CNT_W-1:0] count,
   output logic             done,
   output logic [CHAN_W-1:0] q0,
   output logic [CHAN_W-1:0] q1,
   output logic [CHAN_W-1:0] q2
);
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] n0_ff, n1_ff, n2_ff, n0_in, n1_in, n2_in;
   logic [SUM_W-1:0] qq0_ff, qq1_ff, qq2_ff, qq0_in, qq1_in, qq2_in;
   logic [SUM_W:0]   r0_ff, r1_ff, r2_ff, r0_in, r1_in, r2_in;
   logic [SUM_W:0]   r0_s, r1_s, r2_s, dv;
   logic [CNT_W-1:0] d_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   assign dv = {{(SUM_W+1-CNT_W){1'b0}}, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      n0_in = n0_ff; n1_in = n1_ff; n2_in = n2_ff;
      qq0_in = qq0_ff; qq1_in = qq1_ff; qq2_in = qq2_ff;
      r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff;
      r0_s = {r0_ff[SUM_W-1:0], n0_ff[SUM_W-1]};
      r1_s = {r1_ff[SUM_W-1:0], n1_ff[SUM_W-1]};
      r2_s = {r2_ff[SUM_W-1:0], n2_ff[SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         n0_in = sum0; n1_in = sum1; n2_in = sum2;
         r0_in = '0; r1_in = '0; r2_in = '0;
      end else if (busy_ff) begin
         n0_in = n0_ff << 1; n1_in = n1_ff << 1; n2_in = n2_ff << 1;
         r0_in = (r0_s >= dv) ? r0_s - dv : r0_s;
         r1_in = (r1_s >= dv) ? r1_s - dv : r1_s;
         r2_in = (r2_s >= dv) ? r2_s - dv : r2_s;
         qq0_in = {qq0_ff[SUM_W-2:0], r0_s >= dv};
         qq1_in = {qq1_ff[SUM_W-2:0], r1_s >= dv};
         qq2_in = {qq2_ff[SUM_W-2:0], r2_s >= dv};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      if (start) d_ff <= count;
      n0_ff <= n0_in; n1_ff <= n1_in; n2_ff <= n2_in;
      r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in;
      qq0_ff <= qq0_in; qq1_ff <= qq1_in; qq2_ff <= qq2_in;
   end

   assign done = done_ff;
   assign q0 = qq0_ff[CHAN_W-1:0];
   assign q1 = qq1_ff[CHAN_W-1:0];
   assign q2 = qq2_ff[CHAN_W-1:0];
endmodule

// ----- rtl/superpixel_mean_color.sv -----
// Top level of the superpixel mean color block: label memory, controller
// and output register. Depends on spmc_pkg and spmc_div.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/ready    | req_type
//  rsp_    | out       | rsp_valid/ready    | rsp_type
//  csr_    | in        | csr_we, no wait    | label_count
//
// An accumulate goes through accept, read and write back. A clear bumps a frame
// epoch kept with each entry. When the epoch wraps, and after reset, a clearing
// pass rewrites every entry; no request is taken then. A paint of a live label
// answers once the bit-serial divider is done; one whose label is empty or out of
// range is answered without a divide. A waiting response holds a later paint
// before its divide; other requests go on.
module superpixel_mean_color
   import spmc_pkg::*;
#(
   parameter int MAX_LABELS      = MAX_LABELS_DEF,
   parameter int MAX_PIXELS_LOG2 = MAX_PIXELS_LOG2_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);
   localparam int SUM_W = CHAN_W + MAX_PIXELS_LOG2;
   localparam int CNT_W = MAX_PIXELS_LOG2;
   localparam int ADDR_W = $clog2(MAX_LABELS);
   localparam int EPOCH_W = 4;
   localparam int WORD_W = EPOCH_W + CNT_W + 3 * SUM_W;
   localparam int LIM_W = (ADDR_W + 1 > CSR_W) ? ADDR_W + 1 : CSR_W;

   // Entry layout: epoch mark, count, three sums.
   logic [WORD_W-1:0] mem [MAX_LABELS];
   logic [WORD_W-1:0] rd_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [CSR_W-1:0] lc_ff;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ADDR_W:0] clr_ff, clr_in;
   logic        in_range;
   logic [LIM_W-1:0] lim, lab_x;
   logic        div_start, div_done;
   logic [CHAN_W-1:0] q0, q1, q2;

   logic [EPOCH_W-1:0] e_mark;
   logic [CNT_W-1:0] e_cnt;
   logic [SUM_W-1:0] e_s0, e_s1, e_s2;
   logic             live;

   assign {e_mark, e_cnt, e_s0, e_s1, e_s2} = rd_ff;
   assign live = (e_mark == epoch_ff);

   always_comb begin
      lim = (LIM_W'(lc_ff) > LIM_W'(MAX_LABELS)) ? LIM_W'(MAX_LABELS) : LIM_W'(lc_ff);
      lab_x = LIM_W'(req_ff.label);
      in_range = lab_x < lim;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   spmc_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .sum0(e_s0), .sum1(e_s1), .sum2(e_s2), .count(e_cnt),
      .done(div_done), .q0(q0), .q1(q1), .q2(q2)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      epoch_in = epoch_ff;
      clr_in = clr_ff;
      rd_addr = ADDR_W'(req_ff.label);
      wr_addr = ADDR_W'(req_ff.label);
      wr_data = '0;
      wr_en = 1'b0;
      div_start = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[ADDR_W-1:0];
            wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (ADDR_W+1)'(MAX_LABELS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               case (kind_type'(req_data.kind))
                  KIND_CLEAR: begin
                     epoch_in = epoch_ff + 1'b1;
                     // A wrapped epoch could match stale marks, so rewrite every entry.
                     if (epoch_ff == '1) begin
                        clr_in = '0;
                        state_in = ST_CLEAR;
                     end
                  end
                  KIND_ACCUM, KIND_PAINT: state_in = ST_READ;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            // Read data for the held label is registered this cycle.
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (kind_type'(req_ff.kind) == KIND_ACCUM) begin
               state_in = ST_IDLE;
               if (in_range) begin
                  if (!live) begin
                     wr_en = 1'b1;
                     wr_data = {epoch_ff, CNT_W'(1),
                                SUM_W'(req_ff.in_ch0), SUM_W'(req_ff.in_ch1),
                                SUM_W'(req_ff.in_ch2)};
                  end else if (e_cnt != {CNT_W{1'b1}}) begin
                     wr_en = 1'b1;
                     wr_data = {epoch_ff, e_cnt + 1'b1,
                                e_s0 + SUM_W'(req_ff.in_ch0),
                                e_s1 + SUM_W'(req_ff.in_ch1),
                                e_s2 + SUM_W'(req_ff.in_ch2)};
                  end
               end
            end else if (rsp_valid_ff && !rsp_ready) begin
               // The output register is still taken; hold the paint here.
               state_in = ST_DIV;
            end else if (!in_range || !live || e_cnt == '0) begin
               rsp_in = '0;
               rsp_in.label_error = !in_range;
               rsp_in.empty_label = in_range;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (div_done) begin
               rsp_in = '0;
               rsp_in.mean_ch0 = q0;
               rsp_in.mean_ch1 = q1;
               rsp_in.mean_ch2 = q2;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         epoch_ff <= '0;
         clr_ff <= '0;
         lc_ff <= CSR_W'(1024);
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         epoch_ff <= epoch_in;
         clr_ff <= clr_in;
         if (csr_we) lc_ff <= csr_wdata;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
